// File: rtl/core/pcfd_pkg.sv
`default_nettype none

package pcfd_pkg;

  localparam int TIME_W     = 16;
  localparam int FREQ_W     = 24;
  localparam int DUTY_W     = 7;
  localparam int SCALE_W    = 7;
  localparam int DUTY_SCALE = 100;

  localparam logic [FREQ_W-1:0] TICK_RATE_RESET = 24'd1000000;

  localparam logic CMD_ARM     = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

endpackage

`default_nettype wire

// File: rtl/core/pcfd_channels.sv
`default_nettype none

interface pcfd_cap_if import pcfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] capture_time;
  logic              rising_edge;

  modport source (output valid, command, capture_time, rising_edge, input ready);
  modport sink   (input valid, command, capture_time, rising_edge, output ready);
endinterface

interface pcfd_res_if import pcfd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic [DUTY_W-1:0] duty_percent;
  logic              zero_period;

  modport source (output valid, frequency, duty_percent, zero_period, input ready);
  modport sink   (input valid, frequency, duty_percent, zero_period, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pcfd_front.sv
`default_nettype none

module pcfd_front import pcfd_pkg::*; #(
  parameter int CW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pcfd_cap_if.sink           cap,
  input  wire logic          full,
  output logic               push,
  output logic [CW-1:0]      high_time,
  output logic [CW:0]        period
);

  phase_t          phase, phase_next;
  logic [CW-1:0]   first_rise;
  logic [CW-1:0]   fall;
  logic [CW-1:0]   t;
  logic [CW-1:0]   low_time;
  logic            accept;
  logic            take_rise1;
  logic            take_fall;

  assign cap.ready = !full;
  assign accept    = cap.valid && cap.ready;
  assign t         = CW'(cap.capture_time);

  always_comb begin
    phase_next = phase;
    push       = 1'b0;
    take_rise1 = 1'b0;
    take_fall  = 1'b0;
    if (accept) begin
      if (cap.command == CMD_ARM) begin
        phase_next = PH_RISE1;
      end else begin
        case (phase)
          PH_RISE1: begin
            if (cap.rising_edge) begin
              take_rise1 = 1'b1;
              phase_next = PH_FALL;
            end
          end
          PH_FALL: begin
            if (!cap.rising_edge) begin
              take_fall  = 1'b1;
              phase_next = PH_RISE2;
            end
          end
          PH_RISE2: begin
            if (cap.rising_edge) begin
              push       = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      first_rise <= '0;
      fall       <= '0;
    end else begin
      phase <= phase_next;
      if (take_rise1) begin
        first_rise <= t;
      end
      if (take_fall) begin
        fall <= t;
      end
    end
  end

  // modular differences, period keeps the carry
  assign high_time = fall - first_rise;
  assign low_time  = t - fall;
  assign period    = {1'b0, high_time} + {1'b0, low_time};

endmodule

`default_nettype wire

// File: rtl/core/pcfd_queue.sv
`default_nettype none

module pcfd_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pcfd_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module pcfd_div #(
  parameter int DD_W = 24,
  parameter int DV_W = 17
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [DD_W-1:0] dividend,
  input  wire logic [DV_W-1:0] divisor,
  output logic                 busy,
  output logic [DD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DD_W + 1);

  logic [DV_W-1:0]  rem;
  logic [DV_W-1:0]  dvs;
  logic [CNT_W-1:0] cnt;
  logic [DV_W:0]    trial;
  logic [DV_W:0]    diff;
  logic             ge;

  assign trial = {rem, quotient[DD_W-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CNT_W'(DD_W);
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      quotient <= {quotient[DD_W-2:0], ge};
      cnt      <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pcfd_back.sv
`default_nettype none

module pcfd_back import pcfd_pkg::*; #(
  parameter int CW = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              empty,
  output logic                   pop,
  input  wire logic [CW-1:0]     high_time,
  input  wire logic [CW:0]       period,
  input  wire logic [FREQ_W-1:0] tick_rate,
  pcfd_res_if.source             res
);

  localparam int DUTY_DD_W = CW + SCALE_W;
  localparam int DV_W      = CW + 1;

  back_state_t            state, state_next;
  logic                   start;
  logic                   load;
  logic                   zero;
  logic                   busy_f;
  logic                   busy_d;
  logic [FREQ_W-1:0]      quot_f;
  logic [DUTY_DD_W-1:0]   quot_d;
  logic [DUTY_DD_W-1:0]   scaled_high;

  assign scaled_high = DUTY_DD_W'(high_time) * DUTY_DD_W'(DUTY_SCALE);

  pcfd_div #(.DD_W(FREQ_W), .DV_W(DV_W)) u_div_freq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (tick_rate),
    .divisor  (period),
    .busy     (busy_f),
    .quotient (quot_f)
  );

  pcfd_div #(.DD_W(DUTY_DD_W), .DV_W(DV_W)) u_div_duty (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (scaled_high),
    .divisor  (period),
    .busy     (busy_d),
    .quotient (quot_d)
  );

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    start      = 1'b0;
    load       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          start      = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        // wait for both quotients and a free output register
        if (!busy_f && !busy_d && (!res.valid || res.ready)) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero <= (period == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.zero_period  <= zero;
      res.frequency    <= zero ? '0 : quot_f;
      res.duty_percent <= zero ? '0 : quot_d[DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pwm_capture_freq_duty_top.sv
// PWM frequency and duty measurement from input-capture timestamps. Send an arm
// word (command 0), then capture words (command 1) carrying the counter value and
// edge polarity; the block takes a rising, a falling and a second rising edge, ignores
// edges of the wrong polarity, and returns one result word with frequency =
// tick_rate / period and duty_percent = high * 100 / period, then idles until armed
// again. A zero period gives zero_period = 1 and zero results. Capture words are taken
// in a single cycle each while the two-entry queue between the edge sequencer and the
// arithmetic has room. Each completed period is worked by two restoring dividers in
// parallel, one quotient bit per cycle, and the next period leaves the queue only once
// the result is loaded into the output register. tick_rate is written through cfg_we /
// cfg_wdata and resets to 1000000.
`default_nettype none

module pwm_capture_freq_duty_top import pcfd_pkg::*; #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  pcfd_cap_if.sink               capture_ch,
  pcfd_res_if.source             result_ch,
  input  wire logic              cfg_we,
  input  wire logic [FREQ_W-1:0] cfg_wdata
);

  localparam int JOB_W = 2 * COUNTER_WIDTH + 1;

  logic [FREQ_W-1:0]        tick_rate;
  logic                     push;
  logic                     pop;
  logic                     full;
  logic                     empty;
  logic [COUNTER_WIDTH-1:0] front_high;
  logic [COUNTER_WIDTH:0]   front_period;
  logic [JOB_W-1:0]         job_in;
  logic [JOB_W-1:0]         job_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= TICK_RATE_RESET;
    end else if (cfg_we) begin
      tick_rate <= cfg_wdata;
    end
  end

  pcfd_front #(.CW(COUNTER_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cap       (capture_ch),
    .full      (full),
    .push      (push),
    .high_time (front_high),
    .period    (front_period)
  );

  assign job_in = {front_period, front_high};

  pcfd_queue #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (job_in),
    .full  (full),
    .pop   (pop),
    .dout  (job_out),
    .empty (empty)
  );

  pcfd_back #(.CW(COUNTER_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop       (pop),
    .high_time (job_out[COUNTER_WIDTH-1:0]),
    .period    (job_out[JOB_W-1:COUNTER_WIDTH]),
    .tick_rate (tick_rate),
    .res       (result_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/pcfd_chk.sv
`default_nettype none

module pcfd_chk import pcfd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic [FREQ_W-1:0] frequency,
  input wire logic [DUTY_W-1:0] duty_percent,
  input wire logic              zero_period
);

  // results never appear the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      res_valid && $stable(frequency) && $stable(duty_percent) && $stable(zero_period))
    else $error("stalled result word changed");

  a_zero_forces: assert property (@(posedge clk) disable iff (rst)
    res_valid && zero_period |-> frequency == '0 && duty_percent == '0)
    else $error("zero period with nonzero results");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> duty_percent <= DUTY_W'(DUTY_SCALE))
    else $error("duty above full scale");

endmodule

bind pwm_capture_freq_duty_top pcfd_chk u_pcfd_chk (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (result_ch.valid),
  .res_ready    (result_ch.ready),
  .frequency    (result_ch.frequency),
  .duty_percent (result_ch.duty_percent),
  .zero_period  (result_ch.zero_period)
);

`default_nettype wire
